>>> rtl/core/brbh_pkg.sv
package brbh_pkg;

  // fixed field widths
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned FILL_W     = 16;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned RESERVE_W  = 16;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_HIST_RESERVE = 1'b0;
  localparam logic [RESERVE_W-1:0]  HIST_RESERVE_RST = 16'h8000;

  // result queue depth
  localparam int unsigned RES_DEPTH  = 4;

  // operation codes
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_COPY  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // classified command, front to back
  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  write_byte;
    logic               save_history;
    logic [SKIP_W-1:0]  skip;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   position;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [DATA_W-1:0]   data_byte;
    logic                byte_valid;
    logic                last;
    logic                accepted;
    logic [FILL_W-1:0]   fill_level;
    logic [OFFSET_W-1:0] stream_offset;
  } res_t;

endpackage

>>> rtl/core/brbh_front.sv
module brbh_front #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind,
  input  logic [brbh_pkg::DATA_W-1:0]     write_byte,
  input  logic                            save_history,
  input  logic [brbh_pkg::SKIP_W-1:0]     skip,
  input  logic [brbh_pkg::COUNT_W-1:0]    count,
  input  logic [brbh_pkg::POS_W-1:0]      position,
  output logic                            cmd_valid,
  input  logic                            cmd_take,
  output brbh_pkg::cmd_t                  cmd
);

  localparam logic [brbh_pkg::COUNT_W-1:0] BURST_CAP = brbh_pkg::COUNT_W'(MAX_BURST);

  brbh_pkg::cmd_t             q [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 cnt;
  logic                       do_push;
  logic                       do_pop;
  brbh_pkg::cmd_t             cmd_in;

  // classify: decode kind, clip burst length
  always_comb begin
    cmd_in.kind         = brbh_pkg::kind_t'(kind);
    cmd_in.write_byte   = write_byte;
    cmd_in.save_history = save_history;
    cmd_in.skip         = skip;
    cmd_in.count        = (count > BURST_CAP) ? BURST_CAP : count;
    cmd_in.position     = position;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> rtl/core/brbh_back.sv
module brbh_back #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned RES_DEPTH    = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  brbh_pkg::cmd_t                    cmd,
  output logic                              cmd_take,
  input  logic [brbh_pkg::RESERVE_W-1:0]    hist_reserve,
  input  logic [$clog2(RES_DEPTH+1)-1:0]    res_level,
  output logic                              res_push,
  output brbh_pkg::res_t                    res
);

  localparam int unsigned IW  = $clog2(BUFFER_BYTES);
  localparam int unsigned CW  = (IW > 16) ? IW : 16;
  localparam int unsigned RCW = $clog2(RES_DEPTH+1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_BURST} state_t;

  state_t                           state;
  brbh_pkg::cmd_t                   cur;
  logic [IW-1:0]                    write_index;
  logic [IW-1:0]                    read_index;
  logic [IW-1:0]                    fill_count;
  logic [brbh_pkg::OFFSET_W-1:0]    bytes_written;
  logic [brbh_pkg::COUNT_W-1:0]     rem;
  logic [IW-1:0]                    addr;
  logic                             s1_valid;
  logic                             s1_mem;
  brbh_pkg::res_t                   s1;

  logic [brbh_pkg::DATA_W-1:0]      mem [BUFFER_BYTES];
  logic [brbh_pkg::DATA_W-1:0]      mem_q;
  logic                             mem_we;
  logic                             mem_re;

  logic [RCW:0]                     occ;
  logic                             credit;
  logic [CW-1:0]                    fill_ext;
  logic [CW-1:0]                    fill_inc_ext;
  logic [CW-1:0]                    fill_dec_ext;
  logic [CW-1:0]                    left;
  logic                             wr_ok;
  logic [CW-1:0]                    skip_ext;
  logic [CW-1:0]                    skip_c_ext;
  logic [IW-1:0]                    skip_c;
  logic [IW-1:0]                    fill_after_skip;
  logic [CW-1:0]                    fas_ext;
  logic [brbh_pkg::COUNT_W-1:0]     n_read;
  logic [CW-1:0]                    pos_ext;
  logic                             is_read;

  // room in the result queue, counting the item in the read stage
  assign occ    = (RCW+1)'(res_level) + (RCW+1)'(s1_valid);
  assign credit = (occ < (RCW+1)'(RES_DEPTH));

  // write admission: free space less one, minus reserve when asked
  always_comb begin
    fill_ext     = CW'(fill_count);
    fill_inc_ext = CW'(fill_count + IW'(1));
    fill_dec_ext = CW'(fill_count - IW'(1));
    left         = CW'(BUFFER_BYTES - 1) - fill_ext;
    if (cur.save_history && (hist_reserve != '0)) begin
      wr_ok = (left > CW'(hist_reserve));
    end else begin
      wr_ok = (left != '0);
    end
  end

  // read: clip skip to fill, then burst length to what is left
  always_comb begin
    skip_ext        = CW'(cur.skip);
    skip_c_ext      = (skip_ext > fill_ext) ? fill_ext : skip_ext;
    skip_c          = skip_c_ext[IW-1:0];
    fill_after_skip = fill_count - skip_c;
    fas_ext         = CW'(fill_after_skip);
    n_read          = (CW'(cur.count) < fas_ext) ? cur.count
                                                 : fas_ext[brbh_pkg::COUNT_W-1:0];
    pos_ext         = CW'(cur.position);
  end

  assign is_read  = (cur.kind == brbh_pkg::KIND_READ);
  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign mem_we   = (state == ST_EXEC) && (cur.kind == brbh_pkg::KIND_WRITE) && credit && wr_ok;
  assign mem_re   = (state == ST_BURST) && credit && (rem != '0);

  // byte store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_index] <= cur.write_byte;
    end
    if (mem_re) begin
      mem_q <= mem[addr];
    end
  end

  // sequencer and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_index   <= '0;
      read_index    <= '0;
      fill_count    <= '0;
      bytes_written <= '0;
      rem           <= '0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cur.kind)
            brbh_pkg::KIND_WRITE: begin
              if (credit) begin
                s1_valid         <= 1'b1;
                s1_mem           <= 1'b0;
                s1.data_byte     <= '0;
                s1.byte_valid    <= 1'b0;
                s1.last          <= 1'b1;
                s1.accepted      <= wr_ok;
                if (wr_ok) begin
                  write_index      <= write_index + IW'(1);
                  fill_count       <= fill_count + IW'(1);
                  bytes_written    <= bytes_written + 32'd1;
                  s1.fill_level    <= fill_inc_ext[brbh_pkg::FILL_W-1:0];
                  s1.stream_offset <= bytes_written + 32'd1;
                end else begin
                  s1.fill_level    <= fill_ext[brbh_pkg::FILL_W-1:0];
                  s1.stream_offset <= bytes_written;
                end
                state <= ST_IDLE;
              end
            end
            brbh_pkg::KIND_READ: begin
              read_index <= read_index + skip_c;
              fill_count <= fill_after_skip;
              addr       <= read_index + skip_c;
              rem        <= n_read;
              state      <= ST_BURST;
            end
            brbh_pkg::KIND_COPY: begin
              addr  <= pos_ext[IW-1:0];
              rem   <= cur.count;
              state <= ST_BURST;
            end
            default: begin
              if (credit) begin
                s1_valid         <= 1'b1;
                s1_mem           <= 1'b0;
                s1.data_byte     <= '0;
                s1.byte_valid    <= 1'b0;
                s1.last          <= 1'b1;
                s1.accepted      <= 1'b0;
                s1.fill_level    <= fill_ext[brbh_pkg::FILL_W-1:0];
                s1.stream_offset <= bytes_written;
                state            <= ST_IDLE;
              end
            end
          endcase
        end
        ST_BURST: begin
          if (credit) begin
            s1_valid         <= 1'b1;
            s1.data_byte     <= '0;
            s1.accepted      <= 1'b0;
            s1.stream_offset <= bytes_written;
            if (rem == '0) begin
              // nothing to deliver
              s1_mem        <= 1'b0;
              s1.byte_valid <= 1'b0;
              s1.last       <= 1'b1;
              s1.fill_level <= fill_ext[brbh_pkg::FILL_W-1:0];
              state         <= ST_IDLE;
            end else begin
              s1_mem        <= 1'b1;
              s1.byte_valid <= 1'b1;
              s1.last       <= (rem == brbh_pkg::COUNT_W'(1));
              if (is_read) begin
                read_index    <= read_index + IW'(1);
                fill_count    <= fill_count - IW'(1);
                s1.fill_level <= fill_dec_ext[brbh_pkg::FILL_W-1:0];
              end else begin
                s1.fill_level <= fill_ext[brbh_pkg::FILL_W-1:0];
              end
              addr <= addr + IW'(1);
              rem  <= rem - brbh_pkg::COUNT_W'(1);
              if (rem == brbh_pkg::COUNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // merge memory data into the result
  always_comb begin
    res           = s1;
    res.data_byte = s1_mem ? mem_q : '0;
  end
  assign res_push = s1_valid;

endmodule

>>> rtl/core/brbh_res_fifo.sv
module brbh_res_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  brbh_pkg::res_t                din,
  input  logic                          pop,
  output logic                          empty,
  output brbh_pkg::res_t                dout,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);

  brbh_pkg::res_t   q [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_pop;

  assign empty  = (level == '0);
  assign dout   = q[rd_ptr];
  assign do_pop = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

  // pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   level <= level + LW'(1);
        2'b01:   level <= level - LW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

>>> rtl/core/byte_ring_buffer_with_history.sv
// Channel   Direction  Handshake               Payload
// config    in         psel/penable/pwrite     paddr, pwdata (prdata on reads)
// command   in         push / full             kind, write_byte, save_history,
//                                              skip, count, position
// result    out        empty / pop             data_byte, byte_valid, last,
//                                              accepted, fill_level, stream_offset
//
// Write or unknown command: one status item; read or copy: max(n,1) items, n being the
// bytes delivered, one per cycle from the single store read port while credit allows.
// Commands pass the idle and exec states, reads and copies then the burst state.
// Reset is synchronous; it clears indexes, counts and queues, presets the reserve, not the store.
// A stalled pop fills the 4-entry result queue, the executer then waits on credit,
// and the 2-entry command queue raises full.
module byte_ring_buffer_with_history #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned MAX_BURST    = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [brbh_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [brbh_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [brbh_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           kind,
  input  logic [brbh_pkg::DATA_W-1:0]          write_byte,
  input  logic                                 save_history,
  input  logic [brbh_pkg::SKIP_W-1:0]          skip,
  input  logic [brbh_pkg::COUNT_W-1:0]         count,
  input  logic [brbh_pkg::POS_W-1:0]           position,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [brbh_pkg::DATA_W-1:0]          data_byte,
  output logic                                 byte_valid,
  output logic                                 last,
  output logic                                 accepted,
  output logic [brbh_pkg::FILL_W-1:0]          fill_level,
  output logic [brbh_pkg::OFFSET_W-1:0]        stream_offset
);

  localparam int unsigned RCW = $clog2(brbh_pkg::RES_DEPTH+1);

  logic [brbh_pkg::RESERVE_W-1:0] history_reserve;
  logic                           reg_sel;
  logic                           cmd_valid;
  logic                           cmd_take;
  brbh_pkg::cmd_t                 cmd;
  logic                           res_push;
  brbh_pkg::res_t                 res_in;
  brbh_pkg::res_t                 res_out;
  logic [RCW-1:0]                 res_level;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[brbh_pkg::APB_ADDR_W-1:2] == brbh_pkg::REG_HIST_RESERVE);
  assign prdata  = reg_sel ? brbh_pkg::APB_DATA_W'(history_reserve) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_reserve <= brbh_pkg::HIST_RESERVE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      history_reserve <= pwdata[brbh_pkg::RESERVE_W-1:0];
    end
  end

  // command intake
  brbh_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .write_byte   (write_byte),
    .save_history (save_history),
    .skip         (skip),
    .count        (count),
    .position     (position),
    .cmd_valid    (cmd_valid),
    .cmd_take     (cmd_take),
    .cmd          (cmd)
  );

  // executer with the byte store
  brbh_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .RES_DEPTH    (brbh_pkg::RES_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .hist_reserve (history_reserve),
    .res_level    (res_level),
    .res_push     (res_push),
    .res          (res_in)
  );

  // result queue
  brbh_res_fifo #(
    .DEPTH (brbh_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out),
    .level (res_level)
  );

  assign data_byte     = res_out.data_byte;
  assign byte_valid    = res_out.byte_valid;
  assign last          = res_out.last;
  assign accepted      = res_out.accepted;
  assign fill_level    = res_out.fill_level;
  assign stream_offset = res_out.stream_offset;

  // result queue never overflows thanks to credit
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_level < RCW'(brbh_pkg::RES_DEPTH)))
    else $error("result queue overflow");

  // executer only takes a command that is there
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // nothing waits after reset
  assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RING_BYTES   = 65536;
  localparam int unsigned BURST_MAX    = 64;
  localparam int unsigned DRAIN_TICKS  = 12;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS  = 66;
  localparam int unsigned BURST_WRITES = 20;
  // address bit pattern that maps to no register
  localparam logic [brbh_pkg::APB_ADDR_W-3:0] REG_SPARE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [brbh_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [brbh_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [brbh_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind = '0;
  logic [brbh_pkg::DATA_W-1:0] write_byte = '0;
  logic save_history = 1'b0;
  logic [brbh_pkg::SKIP_W-1:0] skip = '0;
  logic [brbh_pkg::COUNT_W-1:0] count = '0;
  logic [brbh_pkg::POS_W-1:0] position = '0;
  logic empty;
  logic pop = 1'b0;
  logic [brbh_pkg::DATA_W-1:0] data_byte;
  logic byte_valid;
  logic last;
  logic accepted;
  logic [brbh_pkg::FILL_W-1:0] fill_level;
  logic [brbh_pkg::OFFSET_W-1:0] stream_offset;

  byte_ring_buffer_with_history dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .kind(kind), .write_byte(write_byte), .save_history(save_history),
    .skip(skip), .count(count), .position(position),
    .empty(empty), .pop(pop),
    .data_byte(data_byte), .byte_valid(byte_valid), .last(last),
    .accepted(accepted), .fill_level(fill_level), .stream_offset(stream_offset)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ring mirror: store, indexes, counters and the reserve register
  logic [brbh_pkg::DATA_W-1:0]    mirror_mem [0:RING_BYTES-1];
  logic [brbh_pkg::POS_W-1:0]     mirror_wr = '0;
  logic [brbh_pkg::POS_W-1:0]     mirror_rd = '0;
  logic [brbh_pkg::FILL_W-1:0]    mirror_fill = '0;
  logic [brbh_pkg::OFFSET_W-1:0]  mirror_total = '0;
  logic [brbh_pkg::RESERVE_W-1:0] mirror_reserve = brbh_pkg::HIST_RESERVE_RST;

  brbh_pkg::cmd_t cmd_backlog[$];
  brbh_pkg::res_t due_results[$];
  brbh_pkg::cmd_t cur_cmd = '0;
  bit have_cmd = 0;
  bit cmd_took = 0;
  bit res_took = 0;
  bit no_idle = 0;
  int send_wait = -1;
  int pop_wait = 0;
  int drv_calm = 0;
  int mon_calm = 0;
  int unsigned fails = 0;

  function automatic brbh_pkg::cmd_t mk_cmd(brbh_pkg::kind_t k,
                                            logic [brbh_pkg::DATA_W-1:0] b, logic h,
                                            logic [brbh_pkg::SKIP_W-1:0] sk,
                                            logic [brbh_pkg::COUNT_W-1:0] cnt,
                                            logic [brbh_pkg::POS_W-1:0] pos);
    brbh_pkg::cmd_t c;
    c.kind = k;
    c.write_byte = b;
    c.save_history = h;
    c.skip = sk;
    c.count = cnt;
    c.position = pos;
    return c;
  endfunction

  // per-item wait, with occasional back-to-back stretches
  function automatic int draw_gap(inout int calm);
    if (no_idle) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = int'($urandom_range(8, 30));
      return 0;
    end
    return int'($urandom_range(0, 14));
  endfunction

  // expected result items for one command, applied to the mirror
  function automatic void predict_ring(brbh_pkg::cmd_t c);
    int unsigned n, left, sk, k;
    logic [brbh_pkg::POS_W-1:0] a;
    brbh_pkg::res_t r;
    n = (32'(c.count) > BURST_MAX) ? BURST_MAX : 32'(c.count);
    r = '0;
    case (c.kind)
      brbh_pkg::KIND_WRITE: begin
        left = RING_BYTES - 1 - 32'(mirror_fill);
        if (c.save_history && mirror_reserve != '0)
          left = (left > 32'(mirror_reserve)) ? left - 32'(mirror_reserve) : 0;
        if (left > 0) begin
          mirror_mem[mirror_wr] = c.write_byte;
          mirror_wr++;
          mirror_fill++;
          mirror_total++;
          r.accepted = 1'b1;
        end
        n = 0;
      end
      brbh_pkg::KIND_READ: begin
        // skip is clipped to what is held, skipped bytes leave the ring
        sk = (c.skip > mirror_fill) ? 32'(mirror_fill) : 32'(c.skip);
        mirror_rd += brbh_pkg::POS_W'(sk);
        mirror_fill -= brbh_pkg::FILL_W'(sk);
        if (n > 32'(mirror_fill)) n = 32'(mirror_fill);
        for (k = 0; k < n; k++) begin
          r.data_byte = mirror_mem[mirror_rd];
          r.byte_valid = 1'b1;
          mirror_rd++;
          mirror_fill--;
          r.last = (k == n - 1);
          r.fill_level = mirror_fill;
          r.stream_offset = mirror_total;
          due_results.push_back(r);
        end
      end
      brbh_pkg::KIND_COPY: begin
        // position wraps around the ring, indexes stay put
        for (k = 0; k < n; k++) begin
          a = brbh_pkg::POS_W'(32'(c.position) + k);
          r.data_byte = mirror_mem[a];
          r.byte_valid = 1'b1;
          r.last = (k == n - 1);
          r.fill_level = mirror_fill;
          r.stream_offset = mirror_total;
          due_results.push_back(r);
        end
      end
      default: n = 0;
    endcase
    // write, unknown kind and empty answers give a single status item
    if (n == 0) begin
      r.data_byte = '0;
      r.byte_valid = 1'b0;
      r.last = 1'b1;
      r.fill_level = mirror_fill;
      r.stream_offset = mirror_total;
      due_results.push_back(r);
    end
  endfunction

  function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
    fails++;
    $error("%s: expected %0h, got %0h", name, want, got);
  endfunction

  // command driver: new item at the falling edge, taken at the rising edge
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (cmd_took) begin
        cmd_took = 0;
        have_cmd = 0;
      end
      if (!have_cmd && cmd_backlog.size() != 0) begin
        if (send_wait < 0) send_wait = draw_gap(drv_calm);
        if (send_wait == 0) begin
          cur_cmd = cmd_backlog.pop_front();
          have_cmd = 1;
          send_wait = -1;
        end else begin
          send_wait--;
        end
      end
      push <= have_cmd;
      kind <= cur_cmd.kind;
      write_byte <= cur_cmd.write_byte;
      save_history <= cur_cmd.save_history;
      skip <= cur_cmd.skip;
      count <= cur_cmd.count;
      position <= cur_cmd.position;
    end
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      predict_ring(cur_cmd);
      cmd_took = 1;
    end
  end

  // result side: pop with random stalls
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (res_took) begin
        res_took = 0;
        pop_wait = draw_gap(mon_calm);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    brbh_pkg::res_t want;
    if (!rst && pop && !empty) begin
      res_took = 1;
      if (due_results.size() == 0) begin
        fails++;
        $error("result item with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (data_byte !== want.data_byte)
          flag_field("data_byte", 32'(want.data_byte), 32'(data_byte));
        if (byte_valid !== want.byte_valid)
          flag_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
        if (last !== want.last)
          flag_field("last", 32'(want.last), 32'(last));
        if (accepted !== want.accepted)
          flag_field("accepted", 32'(want.accepted), 32'(accepted));
        if (fill_level !== want.fill_level)
          flag_field("fill_level", 32'(want.fill_level), 32'(fill_level));
        if (stream_offset !== want.stream_offset)
          flag_field("stream_offset", want.stream_offset, stream_offset);
      end
    end
  end

  // wait until every item is taken and answered, then let the pipe settle
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || have_cmd || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  // register write, then read back the reserve register
  task automatic cfg_write(input logic [brbh_pkg::APB_ADDR_W-3:0] idx,
                           input logic [brbh_pkg::RESERVE_W-1:0] val);
    logic [brbh_pkg::APB_DATA_W-1:0] got;
    logic [brbh_pkg::APB_DATA_W-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= brbh_pkg::APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == brbh_pkg::REG_HIST_RESERVE) mirror_reserve = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {brbh_pkg::REG_HIST_RESERVE, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    want = brbh_pkg::APB_DATA_W'(mirror_reserve);
    if (got !== want)
      flag_field("prdata", want, got);
  endtask

  // random command; a copy stays inside the first span bytes, all written
  function automatic brbh_pkg::cmd_t rand_cmd(int unsigned span);
    brbh_pkg::cmd_t c;
    int unsigned sel, n;
    c.write_byte = brbh_pkg::DATA_W'($urandom_range(0, 255));
    c.save_history = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    if (sel < 5) c.skip = '0;
    else if (sel < 8) c.skip = brbh_pkg::SKIP_W'($urandom_range(0, 16));
    else c.skip = brbh_pkg::SKIP_W'($urandom_range(0, 65535));
    sel = $urandom_range(0, 9);
    if (sel == 0) c.count = '0;
    else if (sel < 7) c.count = brbh_pkg::COUNT_W'($urandom_range(1, 16));
    else if (sel < 9) c.count = brbh_pkg::COUNT_W'($urandom_range(17, BURST_MAX));
    else c.count = brbh_pkg::COUNT_W'($urandom_range(BURST_MAX + 1, 127));
    sel = $urandom_range(0, 19);
    if (sel < 9) c.kind = brbh_pkg::KIND_WRITE;
    else if (sel < 14) c.kind = brbh_pkg::KIND_READ;
    else if (sel < 19) c.kind = brbh_pkg::KIND_COPY;
    else c.kind = brbh_pkg::KIND_NONE;
    n = (32'(c.count) > BURST_MAX) ? BURST_MAX : 32'(c.count);
    if (c.kind == brbh_pkg::KIND_COPY) begin
      if (n > span) begin
        n = span;
        c.count = brbh_pkg::COUNT_W'(n);
      end
      c.position = brbh_pkg::POS_W'($urandom_range(0, span - n));
    end else begin
      c.position = brbh_pkg::POS_W'($urandom_range(0, 65535));
    end
    return c;
  endfunction

  initial begin
    int unsigned i, ph, span;
    int t;
    logic [brbh_pkg::RESERVE_W-1:0] pick;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ring: reads, zero-length copy, unknown kind
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'h0000, 7'd0, 16'h0000));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'hFF, 1'b1, 16'h0000, 7'd5, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_COPY, 8'h00, 1'b0, 16'hFFFF, 7'd0, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_NONE, 8'hFF, 1'b1, 16'hFFFF, 7'h7F, 16'hFFFF));
    // a few bytes under the reset reserve, then copy, skip+read, skip past fill
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h00, 1'b0, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'hFF, 1'b1, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'hA5, 1'b0, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h5A, 1'b1, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h01, 1'b0, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h80, 1'b1, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_COPY, 8'h00, 1'b0, 16'h0000, 7'd4, 16'h0001));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'h0001, 7'd2, 16'h0000));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'hFFFF, 7'h7F, 16'h0000));
    wait_drained();

    // full reserve refuses a history write only
    cfg_write(brbh_pkg::REG_HIST_RESERVE, 16'hFFFF);
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h3C, 1'b1, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'hC3, 1'b0, '0, '0, '0));
    wait_drained();

    // unmapped address leaves the reserve alone; zero reserve means no limit
    cfg_write(REG_SPARE, 16'h1234);
    cfg_write(brbh_pkg::REG_HIST_RESERVE, 16'h0000);
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'h77, 1'b1, '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'h0000, 7'h7F, 16'h0000));
    wait_drained();

    // reserve boundary: three history writes fit, the fourth is refused
    cfg_write(brbh_pkg::REG_HIST_RESERVE, 16'd65532);
    for (i = 0; i < 4; i++)
      cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE, 8'(8'h10 + i), 1'b1,
                                   '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'h0001, 7'd1, 16'h0000));
    wait_drained();

    // short write burst at full rate; store entries 0 to 30 are then written,
    // copies stay inside them and the read comes up short
    no_idle = 1;
    for (i = 0; i < BURST_WRITES; i++)
      cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_WRITE,
                                   brbh_pkg::DATA_W'($urandom_range(0, 255)), 1'b0,
                                   '0, '0, '0));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_COPY, 8'h00, 1'b0, 16'h0000, 7'd31, 16'h0000));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_COPY, 8'h00, 1'b0, 16'h0000, 7'd11, 16'd20));
    cmd_backlog.push_back(mk_cmd(brbh_pkg::KIND_READ, 8'h00, 1'b0, 16'h0000, 7'd64, 16'h0000));
    wait_drained();
    no_idle = 0;

    // random traffic under several reserve settings
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: pick = 16'h0000;
        1: pick = 16'hFFFF;
        3: pick = brbh_pkg::RESERVE_W'($urandom_range(0, 65535));
        default: begin
          // just around the current free space
          t = 65534 - int'(mirror_fill) - int'($urandom_range(0, 2));
          pick = (t < 0) ? 16'h0000 : brbh_pkg::RESERVE_W'(t);
        end
      endcase
      cfg_write(brbh_pkg::REG_HIST_RESERVE, pick);
      // store entries written so far, all below the running total
      span = (mirror_total > 32'(RING_BYTES)) ? RING_BYTES : 32'(mirror_total);
      for (i = 0; i < PHASE_ITEMS; i++)
        cmd_backlog.push_back(rand_cmd(span));
      wait_drained();
    end

    if (fails == 0)
      $display("byte_ring_buffer_with_history test passed");
    else
      $display("byte_ring_buffer_with_history test failed");
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("byte_ring_buffer_with_history test failed");
    $finish;
  end

endmodule
